// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tbn_pkg.sv =====
// Package with types, widths and helpers of the tangent basis pipeline.
package tbn_pkg;

  // Width of the root search remainder and product registers.
  localparam int unsigned RW = 66;
  // Number of result bits found by the root search (quotient bits 15..0).
  localparam int unsigned QBITS = 16;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2
  } sel_e;

  // Item state carried through the root search stages.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    sel_e               sel;
    logic               neg0;
    logic               neg1;
    logic               degen;
    logic [31:0]        l2;
    logic [RW-1:0]      r0;
    logic [RW-1:0]      r1;
    logic [RW-1:0]      p0;
    logic [RW-1:0]      p1;
    logic [QBITS-1:0]   k0;
    logic [QBITS-1:0]   k1;
  } root_t;

  // Round a Q2.28 value to Q1.14, halves away from zero, saturate to +-1.0.
  function automatic logic signed [15:0] round_sat(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] r;
    logic [15:0] m16;
    mag = v[32] ? (~v + 33'd1) : v;
    r   = (mag + 33'd8192) >> 14;
    m16 = (r > 33'd16384) ? 16'd16384 : r[15:0];
    return v[32] ? (~m16 + 16'd1) : m16;
  endfunction

endpackage

// ===== rtl/tbn_prep.sv =====
// Front stages: least-component select, lane magnitudes, squares, length.
module tbn_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [15:0]  nx_i,
  input  logic signed [15:0]  ny_i,
  input  logic signed [15:0]  nz_i,
  output logic                valid_o,
  output tbn_pkg::root_t      data_o
);
  import tbn_pkg::*;

  logic [15:0] ax, ay, az;
  sel_e        sel_d;
  logic [15:0] m0_d, m1_d;
  logic        neg0_d, neg1_d;

  logic               v0_q, v1_q, v2_q;
  logic signed [15:0] nx0_q, ny0_q, nz0_q, nx1_q, ny1_q, nz1_q;
  sel_e               sel0_q, sel1_q;
  logic               ng00_q, ng10_q, ng01_q, ng11_q;
  logic [15:0]        m0_q, m1_q;
  logic [31:0]        sq0_q, sq1_q;
  root_t              out_q;
  root_t              out_d;

  // Pick the least component and map the two kept ones onto lanes.
  always_comb begin
    ax = nx_i[15] ? (~nx_i + 16'd1) : nx_i;
    ay = ny_i[15] ? (~ny_i + 16'd1) : ny_i;
    az = nz_i[15] ? (~nz_i + 16'd1) : nz_i;
    if (ax <= ay && ax <= az) begin
      sel_d = SEL_X;
      m0_d = az; neg0_d = ~nz_i[15];
      m1_d = ay; neg1_d = ny_i[15];
    end else if (ay <= az) begin
      sel_d = SEL_Y;
      m0_d = az; neg0_d = ~nz_i[15];
      m1_d = ax; neg1_d = nx_i[15];
    end else begin
      sel_d = SEL_Z;
      m0_d = ay; neg0_d = ~ny_i[15];
      m1_d = ax; neg1_d = nx_i[15];
    end
  end

  // Build the search entry state from the squares.
  always_comb begin
    out_d       = '0;
    out_d.nx    = nx1_q;
    out_d.ny    = ny1_q;
    out_d.nz    = nz1_q;
    out_d.sel   = sel1_q;
    out_d.neg0  = ng01_q;
    out_d.neg1  = ng11_q;
    out_d.l2    = sq0_q + sq1_q;
    out_d.degen = (sq0_q + sq1_q) == 32'd0;
    out_d.r0    = RW'(sq0_q) << 30;
    out_d.r1    = RW'(sq1_q) << 30;
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // Advance payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx0_q <= nx_i; ny0_q <= ny_i; nz0_q <= nz_i;
      sel0_q <= sel_d; ng00_q <= neg0_d; ng10_q <= neg1_d;
      m0_q <= m0_d; m1_q <= m1_d;
      nx1_q <= nx0_q; ny1_q <= ny0_q; nz1_q <= nz0_q;
      sel1_q <= sel0_q; ng01_q <= ng00_q; ng11_q <= ng10_q;
      sq0_q <= 32'(m0_q) * 32'(m0_q);
      sq1_q <= 32'(m1_q) * 32'(m1_q);
      out_q <= out_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/tbn_root_step.sv =====
// One bit of the normalizing root search for both lanes.
module tbn_root_step #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tbn_pkg::root_t  data_i,
  output logic            valid_o,
  output tbn_pkg::root_t  data_o
);
  import tbn_pkg::*;

  logic [RW-1:0] lsq, d0, d1;
  logic          take0, take1;
  root_t         data_d;
  root_t         data_q;
  logic          valid_q;

  // Try setting this bit: (k+b)^2*L2 - k^2*L2 = 2b*(k*L2) + b^2*L2.
  always_comb begin
    lsq   = RW'(data_i.l2) << (2 * BIT);
    d0    = (data_i.p0 << (BIT + 1)) + lsq;
    d1    = (data_i.p1 << (BIT + 1)) + lsq;
    take0 = d0 <= data_i.r0;
    take1 = d1 <= data_i.r1;
    data_d = data_i;
    if (take0) begin
      data_d.r0       = data_i.r0 - d0;
      data_d.p0       = data_i.p0 + (RW'(data_i.l2) << BIT);
      data_d.k0[BIT]  = 1'b1;
    end
    if (take1) begin
      data_d.r1       = data_i.r1 - d1;
      data_d.p1       = data_i.p1 + (RW'(data_i.l2) << BIT);
      data_d.k1[BIT]  = 1'b1;
    end
  end

  // Advance valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/tbn_cross.sv =====
// Back stages: tangent rounding, cross product, binormal rounding, output register.
module tbn_cross (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tbn_pkg::root_t     data_i,
  output logic               valid_o,
  output logic signed [15:0] tx_o,
  output logic signed [15:0] ty_o,
  output logic signed [15:0] tz_o,
  output logic signed [15:0] bx_o,
  output logic signed [15:0] by_o,
  output logic signed [15:0] bz_o,
  output logic               degen_o
);
  import tbn_pkg::*;

  logic [15:0]        q0, q1;
  logic signed [15:0] t0, t1;
  logic signed [15:0] tx_d, ty_d, tz_d;

  logic               va_q, vb_q, vc_q;
  logic signed [15:0] nxa_q, nya_q, nza_q, txa_q, tya_q, tza_q;
  logic               dga_q, dgb_q, dgc_q;
  logic signed [15:0] txb_q, tyb_q, tzb_q;
  logic signed [31:0] pyz_q, pzy_q, pzx_q, pxz_q, pxy_q, pyx_q;
  logic signed [15:0] tx_q, ty_q, tz_q, bx_q, by_q, bz_q;

  // Round the root to nearest and place the lanes by the chosen component.
  always_comb begin
    q0 = 16'((17'(data_i.k0) + 17'd1) >> 1);
    q1 = 16'((17'(data_i.k1) + 17'd1) >> 1);
    t0 = data_i.neg0 ? (~q0 + 16'd1) : q0;
    t1 = data_i.neg1 ? (~q1 + 16'd1) : q1;
    case (data_i.sel)
      SEL_X: begin
        tx_d = '0; ty_d = t0; tz_d = t1;
      end
      SEL_Y: begin
        tx_d = t0; ty_d = '0; tz_d = t1;
      end
      SEL_Z: begin
        tx_d = t0; ty_d = t1; tz_d = '0;
      end
      default: begin
        tx_d = '0; ty_d = '0; tz_d = '0;
      end
    endcase
    if (data_i.degen) begin
      tx_d = '0; ty_d = '0; tz_d = '0;
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Advance payload: tangent, products, rounded binormal.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nxa_q <= data_i.nx; nya_q <= data_i.ny; nza_q <= data_i.nz;
      txa_q <= tx_d; tya_q <= ty_d; tza_q <= tz_d;
      dga_q <= data_i.degen;
      pyz_q <= 32'(nya_q) * 32'(tza_q);
      pzy_q <= 32'(nza_q) * 32'(tya_q);
      pzx_q <= 32'(nza_q) * 32'(txa_q);
      pxz_q <= 32'(nxa_q) * 32'(tza_q);
      pxy_q <= 32'(nxa_q) * 32'(tya_q);
      pyx_q <= 32'(nya_q) * 32'(txa_q);
      txb_q <= txa_q; tyb_q <= tya_q; tzb_q <= tza_q;
      dgb_q <= dga_q;
      tx_q <= txb_q; ty_q <= tyb_q; tz_q <= tzb_q;
      bx_q <= round_sat(33'(pyz_q) - 33'(pzy_q));
      by_q <= round_sat(33'(pzx_q) - 33'(pxz_q));
      bz_q <= round_sat(33'(pxy_q) - 33'(pyx_q));
      dgc_q <= dgb_q;
    end
  end

  assign valid_o = vc_q;
  assign tx_o    = tx_q;
  assign ty_o    = ty_q;
  assign tz_o    = tz_q;
  assign bx_o    = bx_q;
  assign by_o    = by_q;
  assign bz_o    = bz_q;
  assign degen_o = dgc_q;

endmodule

// ===== rtl/tangent_basis_from_normal_core.sv =====
// Takes one Q1.14 normal per cycle while the output is not stalled, and
// returns a unit tangent and the binormal n x t, both Q1.14, rounded to
// nearest and saturated, plus a degenerate flag when the tangent would have
// zero length. The block is a 22-stage pipeline: three front stages (select,
// squares, length), sixteen stages of the bit-serial root search that
// normalizes the tangent, and three back stages (tangent rounding,
// cross-product multipliers, binormal rounding into the output register).
// A new request enters every cycle, but a stall at the output freezes the whole pipe.
module tangent_basis_from_normal_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] tangent_x_o,
  output logic signed [15:0] tangent_y_o,
  output logic signed [15:0] tangent_z_o,
  output logic signed [15:0] binormal_x_o,
  output logic signed [15:0] binormal_y_o,
  output logic signed [15:0] binormal_z_o,
  output logic               degenerate_o
);
  import tbn_pkg::*;

  logic  en;
  logic  sv [QBITS+1];
  root_t sd [QBITS+1];

  // Hold everything while a finished request waits at the output.
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = out_valid_o & out_stall_i;

  tbn_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .nx_i    (normal_x_i),
    .ny_i    (normal_y_i),
    .nz_i    (normal_z_i),
    .valid_o (sv[0]),
    .data_o  (sd[0])
  );

  // Root search, most significant bit first.
  for (genvar g = 0; g < QBITS; g++) begin : g_step
    tbn_root_step #(
      .BIT (QBITS - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[g]),
      .data_i  (sd[g]),
      .valid_o (sv[g+1]),
      .data_o  (sd[g+1])
    );
  end

  tbn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv[QBITS]),
    .data_i  (sd[QBITS]),
    .valid_o (out_valid_o),
    .tx_o    (tangent_x_o),
    .ty_o    (tangent_y_o),
    .tz_o    (tangent_z_o),
    .bx_o    (binormal_x_o),
    .by_o    (binormal_y_o),
    .bz_o    (binormal_z_o),
    .degen_o (degenerate_o)
  );

endmodule

// ===== rtl/tbn_checker.sv =====
// Port-level checker for the tangent basis core, bound to the top level.
`include "assert_macros.svh"

module tbn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] tangent_x_o,
  input logic signed [15:0] tangent_y_o,
  input logic signed [15:0] tangent_z_o,
  input logic               degenerate_o
);

  logic t_zero;
  assign t_zero = (tangent_x_o == 16'sd0) && (tangent_y_o == 16'sd0) &&
                  (tangent_z_o == 16'sd0);

  `TBN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")
  `TBN_ASSERT_NOW(a_in_stall, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output stall")
  `TBN_ASSERT_NOW(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o, t_zero, "degenerate result with nonzero tangent")
  `TBN_ASSERT_NOW(a_tangent_live, clk_i, rst_ni, out_valid_o && !degenerate_o, !t_zero, "zero tangent without degenerate flag")

endmodule

bind tangent_basis_from_normal_core tbn_checker u_tbn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .tangent_x_o  (tangent_x_o),
  .tangent_y_o  (tangent_y_o),
  .tangent_z_o  (tangent_z_o),
  .degenerate_o (degenerate_o)
);
